FILE: design/hcbd_pkg.sv
// Shared constants, types and helper functions for the HTTP chunked body decoder.
// Used by the channel interfaces and by the top level; depends on nothing.
`timescale 1ns / 1ps

package hcbd_pkg;

	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned COUNT_OUT_W    = 32;
	localparam int unsigned CHUNK_W        = 32;
	localparam int unsigned HEX_DIGIT_BITS = 4;
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	localparam logic [BYTE_W-1:0] CH_CR   = 8'd13;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'd10;
	localparam logic [BYTE_W-1:0] CH_SEMI = 8'd59;

	typedef struct packed {
		logic                      ok;
		logic [HEX_DIGIT_BITS-1:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [BYTE_W-1:0] b);
		hex_t r;
		r.ok  = 1'b0;
		r.val = '0;
		if (b >= 8'd48 && b <= 8'd57) begin
			r.ok  = 1'b1;
			r.val = HEX_DIGIT_BITS'(b - 8'd48);
		end else if (b >= 8'd97 && b <= 8'd102) begin
			r.ok  = 1'b1;
			r.val = HEX_DIGIT_BITS'(b - 8'd87);
		end else if (b >= 8'd65 && b <= 8'd70) begin
			r.ok  = 1'b1;
			r.val = HEX_DIGIT_BITS'(b - 8'd55);
		end
		return r;
	endfunction

endpackage

FILE: design/hcbd_ifs.sv
// Valid/ready channel interfaces for the decoder: the received byte stream and the
// decoded body result stream. Depends on hcbd_pkg for field widths.
`timescale 1ns / 1ps

interface hcbd_in_if;
	import hcbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface hcbd_out_if;
	import hcbd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [BYTE_W-1:0]      payload_byte;
	logic                   payload_valid;
	logic                   transfer_done;
	logic                   protocol_error;
	logic [COUNT_OUT_W-1:0] content_count;

	modport source (output valid, output payload_byte, output payload_valid,
		output transfer_done, output protocol_error, output content_count, input ready);
	modport sink   (input valid, input payload_byte, input payload_valid,
		input transfer_done, input protocol_error, input content_count, output ready);
endinterface

FILE: design/http_chunked_body_decoder.sv
// HTTP response body decoder: header skip, plain pass-through and chunked decoding.
// Depends on hcbd_pkg and on the channel interfaces in hcbd_ifs.sv.
//
// Usage: response bytes enter on the stream channel, one byte per transaction. For every
// byte exactly one result transaction leaves on the body channel. It carries the byte with
// payload_valid set when the byte is body content (else zero with payload_valid clear),
// the transfer_done and protocol_error flags, and the saturating count of delivered bytes.
// The user must write the chunked_mode register through cfg_we/cfg_wdata only while
// the block is idle (not enforced); it is sampled at the end of the header CR LF CR LF.
// Stream bytes enter the input register; the parse update then writes the result register,
// which drives body. Throughput is one byte per cycle while body.ready is high, because
// each byte needs only one small update of the parse state between those two registers.
// When the receiver stalls, the result register holds and the input register still
// takes one more byte; then stream.ready drops until body.ready returns.
// Reset clears the parse state, the counter and chunked_mode and empties both registers;
// the block takes input as soon as reset is released.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
	parameter int unsigned COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	hcbd_in_if.sink    stream,
	hcbd_out_if.source body
);
	import hcbd_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PLAIN,
		PH_SIZE,
		PH_DATA,
		PH_CRLF,
		PH_DONE,
		PH_ERROR
	} phase_t;

	logic chunked_mode_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	phase_t             phase_q, phase_d;
	logic [1:0]         hdr_q, hdr_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;
	logic               digit_q, digit_d;
	logic               ext_q, ext_d;
	logic               cr_q, cr_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

	logic              valid_s2;
	logic [BYTE_W-1:0] payload_byte_s2;
	logic              payload_valid_s2;
	logic              done_s2;
	logic              error_s2;

	logic deliver;
	logic advance;
	logic fire;
	logic in_take;
	hex_t hv;
	logic [63:0] cnt_ext;

	assign advance      = !valid_s2 || body.ready;
	assign stream.ready = !valid_s1 || advance;
	assign in_take      = stream.valid && stream.ready;
	assign fire         = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
			valid_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				chunked_mode_q <= cfg_wdata;
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= stream.data_byte;
		end
	end

	assign hv = hex_decode(byte_s1);

	always_comb begin
		phase_d = phase_q;
		hdr_d   = hdr_q;
		chunk_d = chunk_q;
		digit_d = digit_q;
		ext_d   = ext_q;
		cr_d    = cr_q;
		deliver = 1'b0;
		unique case (phase_q) inside
			PH_HEADER: begin
				if (byte_s1 == (hdr_q[0] ? CH_LF : CH_CR)) begin
					if (hdr_q == 2'd3) begin
						hdr_d = 2'd0;
						if (chunked_mode_q) begin
							phase_d = PH_SIZE;
							chunk_d = '0;
							digit_d = 1'b0;
							ext_d   = 1'b0;
							cr_d    = 1'b0;
						end else begin
							phase_d = PH_PLAIN;
						end
					end else begin
						hdr_d = hdr_q + 2'd1;
					end
				end else begin
					hdr_d = (byte_s1 == CH_CR) ? 2'd1 : 2'd0;
				end
			end
			PH_PLAIN: begin
				deliver = 1'b1;
			end
			PH_SIZE: begin
				if (cr_q) begin
					if (byte_s1 != CH_LF || !digit_q) begin
						phase_d = PH_ERROR;
					end else begin
						cr_d    = 1'b0;
						ext_d   = 1'b0;
						phase_d = (chunk_q == '0) ? PH_DONE : PH_DATA;
					end
				end else if (byte_s1 == CH_CR) begin
					cr_d = 1'b1;
				end else if (ext_q) begin
					ext_d = 1'b1;
				end else if (byte_s1 == CH_SEMI) begin
					ext_d = 1'b1;
				end else if (!hv.ok || chunk_q[CHUNK_W-1 -: HEX_DIGIT_BITS] != '0) begin
					// Another digit while the top nibble is non-zero would overflow the 32-bit size.
					phase_d = PH_ERROR;
				end else begin
					chunk_d = {chunk_q[CHUNK_W-HEX_DIGIT_BITS-1:0], hv.val};
					digit_d = 1'b1;
				end
			end
			PH_DATA: begin
				deliver = 1'b1;
				chunk_d = chunk_q - CHUNK_W'(1);
				if (chunk_q == CHUNK_W'(1)) begin
					phase_d = PH_CRLF;
					cr_d    = 1'b0;
				end
			end
			PH_CRLF: begin
				if (!cr_q) begin
					if (byte_s1 == CH_CR) begin
						cr_d = 1'b1;
					end else begin
						phase_d = PH_ERROR;
					end
				end else if (byte_s1 == CH_LF) begin
					phase_d = PH_SIZE;
					chunk_d = '0;
					digit_d = 1'b0;
					ext_d   = 1'b0;
					cr_d    = 1'b0;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_DONE, PH_ERROR: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase
		cnt_d = (deliver && cnt_q != '1) ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HEADER;
			hdr_q            <= 2'd0;
			chunk_q          <= '0;
			digit_q          <= 1'b0;
			ext_q            <= 1'b0;
			cr_q             <= 1'b0;
			cnt_q            <= '0;
			valid_s2         <= 1'b0;
			payload_valid_s2 <= 1'b0;
			done_s2          <= 1'b0;
			error_s2         <= 1'b0;
			payload_byte_s2  <= '0;
		end else begin
			if (fire) begin
				phase_q          <= phase_d;
				hdr_q            <= hdr_d;
				chunk_q          <= chunk_d;
				digit_q          <= digit_d;
				ext_q            <= ext_d;
				cr_q             <= cr_d;
				cnt_q            <= cnt_d;
				valid_s2         <= 1'b1;
				payload_valid_s2 <= deliver;
				payload_byte_s2  <= deliver ? byte_s1 : '0;
				done_s2          <= (phase_d == PH_DONE);
				error_s2         <= (phase_d == PH_ERROR);
			end else if (body.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// The count register is updated together with the result, so it already matches it.
	assign cnt_ext = 64'(cnt_q);

	assign body.valid          = valid_s2;
	assign body.payload_byte   = payload_byte_s2;
	assign body.payload_valid  = payload_valid_s2;
	assign body.transfer_done  = done_s2;
	assign body.protocol_error = error_s2;
	assign body.content_count  = cnt_ext[COUNT_OUT_W-1:0];

	a_deliver_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && payload_valid_s2 |-> !done_s2 && !error_s2)
		else $error("body byte delivered together with a done or error flag");

	a_done_error_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_s2 && error_s2))
		else $error("transfer_done and protocol_error both set");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("done phase left");

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> chunk_q != '0)
		else $error("data phase with no bytes left in the chunk");

endmodule
